// File: hdl/lcg_pkg.sv
// shared types and constants of the lexicographic combination generator
package lcg_pkg;

    localparam int MAX_SET_DEF = 16;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 64;

    localparam logic [CFG_AW-1:0] REG_SET_SIZE     = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CHOOSE_COUNT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_CHARS_LOW    = 2'd2;
    localparam logic [CFG_AW-1:0] REG_CHARS_HIGH   = 2'd3;

    localparam logic [4:0]  RST_SET_SIZE     = 5'd3;
    localparam logic [4:0]  RST_CHOOSE_COUNT = 5'd2;
    localparam logic [63:0] RST_CHARS_LOW    = 64'd6513249;
    localparam logic [63:0] RST_CHARS_HIGH   = 64'd0;

    typedef struct packed {
        logic [4:0]   n;
        logic [4:0]   k;
        logic [127:0] chars;
    } t_cfg;

endpackage

// File: hdl/lcg_index_mem.sv
// index store: synchronous memory with per-entry valid bits, empty entry i reads as i
module lcg_index_mem
    import lcg_pkg::*;
#(
    parameter int DEPTH = MAX_SET_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [3:0]               o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [3:0]               i_wr_data
);

    logic [3:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [3:0]       r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : 4'(i_rd_addr);
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/lcg_cfg.sv
// configuration registers and saturation of n and k
module lcg_cfg
    import lcg_pkg::*;
#(
    parameter int P_MAX_SET = MAX_SET_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg,
    output logic              o_reload
);

    localparam logic [4:0] LP_MAX = 5'(P_MAX_SET);

    logic [4:0]  r_set_size;
    logic [4:0]  r_choose_count;
    logic [63:0] r_chars_low;
    logic [63:0] r_chars_high;
    logic [4:0]  w_n;
    logic [4:0]  w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size     <= RST_SET_SIZE;
            r_choose_count <= RST_CHOOSE_COUNT;
            r_chars_low    <= RST_CHARS_LOW;
            r_chars_high   <= RST_CHARS_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SET_SIZE:     r_set_size     <= i_cfg_data[4:0];
                REG_CHOOSE_COUNT: r_choose_count <= i_cfg_data[4:0];
                REG_CHARS_LOW:    r_chars_low    <= i_cfg_data;
                REG_CHARS_HIGH:   r_chars_high   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_n = r_set_size;
        if (w_n == 5'd0) w_n = 5'd1;
        if (w_n > LP_MAX) w_n = LP_MAX;
        w_k = r_choose_count;
        if (w_k == 5'd0) w_k = 5'd1;
        if (w_k > LP_MAX) w_k = LP_MAX;
        if (w_k > w_n) w_k = w_n;
    end

    assign o_cfg.n     = w_n;
    assign o_cfg.k     = w_k;
    assign o_cfg.chars = {r_chars_high, r_chars_low};

    assign o_reload = i_cfg_we &&
        (i_cfg_addr == REG_SET_SIZE || i_cfg_addr == REG_CHOOSE_COUNT);

endmodule

// File: hdl/lexicographic_combination_generator_core.sv
// top level: sequencer that emits one combination per transfer and steps the index store
// after the input transfer the index store is read in S_RD; in S_EMIT the results are then
//   loaded, one result a cycle while the output is not stalled; each item takes k reads of
//   the index store and, if an index can grow, a write-back of each index from it to the end
// the output register lets the next input transfer happen while a result still waits
// reset (synchronous): configuration to defaults, index store reads as 0..15 at once
module lexicographic_combination_generator_core
    import lcg_pkg::*;
#(
    parameter int P_MAX_SET = MAX_SET_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_restart,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_character,
    output logic [3:0]        o_position,
    output logic [3:0]        o_set_index,
    output logic              o_last,
    output logic              o_has_more
);

    localparam int LP_AW = $clog2(P_MAX_SET);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_WR   = 2'd3;

    t_cfg             w_cfg;
    logic             w_reload;
    logic [3:0]       w_rd_val;
    logic             w_rd_en;
    logic [LP_AW-1:0] w_rd_addr;
    logic             w_wr_en;
    logic             w_clear;

    logic [1:0]       r_state, n_state;
    logic [LP_AW-1:0] r_p, n_p;
    logic             r_more, n_more;
    logic             r_grow_hit, n_grow_hit;
    logic [LP_AW-1:0] r_grow, n_grow;
    logic [3:0]       r_wval, n_wval;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_character;
    logic [3:0]       r_position;
    logic [3:0]       r_set_index;
    logic             r_last;
    logic             r_has_more;

    logic             w_accept;
    logic             w_out_free;
    logic             w_first;
    logic             w_last_now;
    logic             w_more_now;
    logic             w_hit_now;
    logic [4:0]       w_span;
    logic [4:0]       w_limit;
    logic             w_load;

    lcg_cfg #(
        .P_MAX_SET (P_MAX_SET)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_reload   (w_reload)
    );

    lcg_index_mem #(
        .DEPTH (P_MAX_SET)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_val),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_p),
        .i_wr_data (r_wval)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_clear    = w_reload || (w_accept && i_restart);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_first    = (r_p == '0);
    assign w_last_now = (5'(r_p) == (w_cfg.k - 5'd1));
    assign w_span     = w_cfg.n - w_cfg.k;
    assign w_limit    = w_span + 5'(r_p);
    assign w_hit_now  = ({1'b0, w_rd_val} < w_limit);
    assign w_more_now = w_first ? ({1'b0, w_rd_val} < w_span) : r_more;
    assign w_load     = (r_state == S_EMIT) && w_out_free;

    assign w_rd_en   = (r_state == S_RD) || (w_load && !w_last_now);
    assign w_rd_addr = (r_state == S_RD) ? '0 : LP_AW'(r_p + 1'b1);
    assign w_wr_en   = (r_state == S_WR);

    always_comb begin
        n_state     = r_state;
        n_p         = r_p;
        n_more      = r_more;
        n_grow_hit  = r_grow_hit;
        n_grow      = r_grow;
        n_wval      = r_wval;
        n_out_valid = r_out_valid;
        if (!i_out_stall) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RD;
                    n_p     = '0;
                end
            end
            S_RD: begin
                n_state    = S_EMIT;
                n_grow_hit = 1'b0;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_more      = w_more_now;
                    if (w_hit_now) begin
                        n_grow_hit = 1'b1;
                        n_grow     = r_p;
                        n_wval     = w_rd_val + 4'd1;
                    end
                    if (w_last_now) begin
                        if (w_hit_now) begin
                            n_state = S_WR;
                            n_p     = r_p;
                        end else if (r_grow_hit) begin
                            n_state = S_WR;
                            n_p     = r_grow;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_p = LP_AW'(r_p + 1'b1);
                    end
                end
            end
            S_WR: begin
                if (w_last_now) begin
                    n_state = S_IDLE;
                end else begin
                    n_p    = LP_AW'(r_p + 1'b1);
                    n_wval = r_wval + 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_p         <= '0;
            r_more      <= 1'b0;
            r_grow_hit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p         <= n_p;
            r_more      <= n_more;
            r_grow_hit  <= n_grow_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grow <= n_grow;
        r_wval <= n_wval;
        if (w_load) begin
            r_character <= w_cfg.chars[{w_rd_val, 3'b000} +: 8];
            r_position  <= 4'(r_p);
            r_set_index <= w_rd_val;
            r_last      <= w_last_now;
            r_has_more  <= w_more_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_character;
    assign o_position  = r_position;
    assign o_set_index = r_set_index;
    assign o_last      = r_last;
    assign o_has_more  = r_has_more;

endmodule
